// ===== rtl/core/dhot_pkg.sv =====
// Package for the double-hash open-addressed table: types, codes, constants
// and the hash step functions. Used by every other file of the block but dhot_ram.
// No dependencies.
package dhot_pkg;

    localparam int SLOTS_DEF      = 64;
    localparam int MAX_REHASH_DEF = 16;
    localparam int CFG_W          = 7;
    localparam int KEY_W          = 32;
    localparam int VAL_W          = 32;
    localparam int SLOT_OUT_W     = 6;
    localparam int CFG_RESET      = 64;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_DELETE = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_NOPROBE  = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MS_ROT  = 2'd0,
        MS_H1   = 2'd1,
        MS_ONES = 2'd2
    } mod_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_HASH,
        S_HFIN,
        S_MROT,
        S_MROT_W,
        S_MH1,
        S_MH1_W,
        S_MC,
        S_MC_W,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CK,
        S_PROBE_INS,
        S_PROBE_RD,
        S_PROBE_CK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic     in_ready;
        logic     load;
        logic     rehash_start;
        logic     hash_step;
        logic     oat_fin;
        logic     mod_start;
        mod_sel_t mod_sel;
        logic     take_h2;
        logic     take_r;
        logic     take_c;
        logic     idx_clr;
        logic     idx_inc;
        logic     adv;
        logic     rd_scan;
        logic     ins_write;
        logic     res_hit;
        logic     del_mark;
        logic     res_code_we;
        status_t  res_code;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic       in_valid;
        logic       out_free;
        logic       hash_last;
        logic       oat_mode;
        logic       mod_done;
        logic       mod_zero;
        logic       tries_max;
        logic [1:0] func;
        logic       full;
        logic       empty;
        logic       scan_hit;
        logic       i_last;
        logic       probe_free;
        logic       probe_hit;
    } sts_t;

    // One byte of the one-at-a-time hash.
    function automatic logic [31:0] oat_byte(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] a;
        logic [31:0] c;
        a = h + {24'd0, b};
        c = a + (a << 10);
        return c ^ (c >> 6);
    endfunction

    // Final mixing of the one-at-a-time hash.
    function automatic logic [31:0] oat_final(input logic [31:0] h);
        logic [31:0] a;
        logic [31:0] c;
        a = h + (h << 3);
        c = a ^ (a >> 11);
        return c + (c << 15);
    endfunction

    // One byte of the rotate-subtract hash.
    function automatic logic [31:0] rot_byte(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] a;
        a = h + {24'd0, b};
        return a - {a[18:0], a[31:19]};
    endfunction

endpackage

// ===== rtl/core/dhot_req_if.sv =====
// Request channel of the double-hash table: valid/ready plus one operation.
// Depends on dhot_pkg.
interface dhot_req_if import dhot_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               func;
    logic signed [KEY_W-1:0]  key;
    logic [VAL_W-1:0]         value;

    modport source (output valid, func, key, value, input ready);
    modport sink   (input valid, func, key, value, output ready);
endinterface

// ===== rtl/core/dhot_rsp_if.sv =====
// Response channel of the double-hash table: valid/ready plus one result.
// Depends on dhot_pkg.
interface dhot_rsp_if import dhot_pkg::*; ();
    logic                  valid;
    logic                  ready;
    status_t               status;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [VAL_W-1:0]      found_value;
    logic                  was_deleted;

    modport source (output valid, status, slot_index, found_value, was_deleted, input ready);
    modport sink   (input valid, status, slot_index, found_value, was_deleted, output ready);
endinterface

// ===== rtl/core/dhot_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
module dhot_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/dhot_mod.sv =====
// Bit-serial remainder unit: 32-bit dividend modulo a small divisor,
// one dividend bit per cycle. Depends on dhot_pkg.
module dhot_mod import dhot_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [31:0]                  dividend,
    input  logic [$clog2(SLOTS+1)-1:0]   divisor,
    output logic                         done,
    output logic [$clog2(SLOTS)-1:0]     rem
);
    localparam int M_W = $clog2(SLOTS + 1);
    localparam int IDX_W = $clog2(SLOTS);

    logic            busy_reg;
    logic            done_reg;
    logic [4:0]      cnt_reg;
    logic [31:0]     dv_reg;
    logic [M_W-1:0]  rem_reg;
    logic [M_W:0]    trial;
    logic [M_W:0]    rem_next;

    always_comb
    begin
        trial = {rem_reg, dv_reg[31]};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = trial - {1'b0, divisor};
        end
        else
        begin
            rem_next = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dv_reg  <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dv_reg  <= {dv_reg[30:0], 1'b0};
            rem_reg <= rem_next[M_W-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[IDX_W-1:0];
endmodule

// ===== rtl/core/dhot_datapath.sv =====
// Datapath of the double-hash table: hashes, probe arithmetic, slot flags,
// key/value RAMs, result and output registers. Depends on dhot_pkg,
// dhot_req_if, dhot_rsp_if, dhot_ram and dhot_mod.
module dhot_datapath import dhot_pkg::*; #(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int MAX_REHASH = MAX_REHASH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    dhot_req_if.sink         req,
    dhot_rsp_if.source       rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  cmd_t             cmd,
    output sts_t             sts
);
    localparam int IDX_W = $clog2(SLOTS);
    localparam int M_W   = $clog2(SLOTS + 1);
    localparam int RW    = IDX_W + 1;
    localparam int T_W   = $clog2(MAX_REHASH + 1);
    localparam int M_RST = (SLOTS < CFG_RESET) ? SLOTS : CFG_RESET;

    logic [M_W-1:0]   m_reg;
    logic [M_W-1:0]   m_next;
    logic [M_W-1:0]   count_reg;
    logic [SLOTS-1:0] busy_reg;
    logic [SLOTS-1:0] deleted_reg;

    logic [1:0]       func_reg;
    logic [31:0]      key_reg;
    logic [31:0]      val_reg;
    logic [31:0]      hsrc_reg;
    logic [31:0]      oh_reg;
    logic [31:0]      rh_reg;
    logic [1:0]       bcnt_reg;
    logic             oat_mode_reg;
    logic [T_W-1:0]   tries_reg;
    logic [IDX_W-1:0] h2_reg;
    logic [IDX_W-1:0] r_reg;
    logic [IDX_W-1:0] r_next;
    logic [31:0]      s_reg;
    logic [IDX_W-1:0] c_reg;
    logic [IDX_W-1:0] i_reg;

    status_t          res_status_reg;
    logic [IDX_W-1:0] res_slot_reg;
    logic [31:0]      res_fval_reg;
    logic             res_wdel_reg;
    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [IDX_W-1:0] out_slot_reg;
    logic [31:0]      out_fval_reg;
    logic             out_wdel_reg;

    logic [7:0]       hbyte;
    logic [31:0]      mod_dividend;
    logic             mod_done;
    logic [IDX_W-1:0] mod_rem;
    logic [RW-1:0]    c_plus;
    logic [32:0]      sum33;
    logic [RW-1:0]    r1;
    logic [RW-1:0]    r1m;
    logic [RW-1:0]    r2;
    logic [IDX_W-1:0] raddr;
    logic [31:0]      key_rd;
    logic [31:0]      val_rd;

    // Saturate the written size into the supported range.
    always_comb
    begin
        if (cfg_wdata < CFG_W'(2))
        begin
            m_next = M_W'(2);
        end
        else if (32'(cfg_wdata) > 32'(SLOTS))
        begin
            m_next = M_W'(SLOTS);
        end
        else
        begin
            m_next = M_W'(cfg_wdata);
        end
    end

    assign hbyte = 8'(hsrc_reg >> {bcnt_reg, 3'b000});

    always_comb
    begin
        case (cmd.mod_sel)
            MS_ROT:  mod_dividend = rh_reg;
            MS_H1:   mod_dividend = oh_reg;
            MS_ONES: mod_dividend = 32'hFFFF_FFFF;
            default: mod_dividend = rh_reg;
        endcase
    end

    dhot_mod #(
        .SLOTS (SLOTS)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (mod_dividend),
        .divisor  (m_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // c = 2^32 mod m, from (2^32 - 1) mod m.
    assign c_plus = RW'(mod_rem) + RW'(1);

    // Next probe: residue of the wrapped 32-bit sum, tracked incrementally.
    always_comb
    begin
        sum33 = {1'b0, s_reg} + 33'(h2_reg);
        r1    = RW'(r_reg) + RW'(h2_reg);
        if (r1 >= RW'(m_reg))
        begin
            r1m = r1 - RW'(m_reg);
        end
        else
        begin
            r1m = r1;
        end
        if (!sum33[32])
        begin
            r2 = r1m;
        end
        else if (r1m >= RW'(c_reg))
        begin
            r2 = r1m - RW'(c_reg);
        end
        else
        begin
            r2 = r1m + RW'(m_reg) - RW'(c_reg);
        end
        r_next = r2[IDX_W-1:0];
    end

    assign raddr = cmd.rd_scan ? i_reg : r_reg;

    dhot_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (cmd.ins_write),
        .waddr (r_reg),
        .wdata (key_reg),
        .raddr (raddr),
        .rdata (key_rd)
    );

    dhot_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SLOTS)
    ) u_val_ram (
        .clk   (clk),
        .we    (cmd.ins_write),
        .waddr (r_reg),
        .wdata (val_reg),
        .raddr (raddr),
        .rdata (val_rd)
    );

    // Control state: size, fill count, slot flags, rehash count, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg         <= M_W'(M_RST);
            count_reg     <= '0;
            busy_reg      <= '0;
            deleted_reg   <= '0;
            tries_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                m_reg <= m_next;
            end
            if (cmd.load)
            begin
                tries_reg <= '0;
            end
            else if (cmd.rehash_start)
            begin
                tries_reg <= tries_reg + T_W'(1);
            end
            if (cmd.ins_write)
            begin
                busy_reg[r_reg]    <= 1'b1;
                deleted_reg[r_reg] <= 1'b0;
                count_reg          <= count_reg + M_W'(1);
            end
            if (cmd.del_mark)
            begin
                deleted_reg[r_reg] <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg     <= req.func;
            key_reg      <= req.key;
            val_reg      <= req.value;
            hsrc_reg     <= req.key;
            oh_reg       <= '0;
            rh_reg       <= '0;
            bcnt_reg     <= '0;
            oat_mode_reg <= 1'b1;
        end
        else if (cmd.rehash_start)
        begin
            hsrc_reg     <= rh_reg;
            rh_reg       <= '0;
            bcnt_reg     <= '0;
            oat_mode_reg <= 1'b0;
        end
        else if (cmd.hash_step)
        begin
            rh_reg   <= rot_byte(rh_reg, hbyte);
            bcnt_reg <= bcnt_reg + 2'd1;
            if (oat_mode_reg)
            begin
                oh_reg <= oat_byte(oh_reg, hbyte);
            end
        end
        else if (cmd.oat_fin)
        begin
            oh_reg <= oat_final(oh_reg);
        end

        if (cmd.take_h2)
        begin
            h2_reg <= (mod_rem == '0) ? IDX_W'(1) : mod_rem;
        end
        if (cmd.take_r)
        begin
            r_reg <= mod_rem;
            s_reg <= oh_reg;
        end
        else if (cmd.adv)
        begin
            r_reg <= r_next;
            s_reg <= sum33[31:0];
        end
        if (cmd.take_c)
        begin
            c_reg <= (c_plus == RW'(m_reg)) ? '0 : c_plus[IDX_W-1:0];
        end
        if (cmd.idx_clr)
        begin
            i_reg <= '0;
        end
        else if (cmd.idx_inc || cmd.adv)
        begin
            i_reg <= i_reg + IDX_W'(1);
        end

        if (cmd.load)
        begin
            res_status_reg <= ST_NOTFOUND;
            res_slot_reg   <= '0;
            res_fval_reg   <= '0;
            res_wdel_reg   <= 1'b0;
        end
        else if (cmd.res_code_we)
        begin
            res_status_reg <= cmd.res_code;
        end
        else if (cmd.res_hit)
        begin
            if (res_status_reg != ST_OK)
            begin
                res_status_reg <= ST_OK;
                res_slot_reg   <= r_reg;
            end
            if (func_reg == FN_LOOKUP)
            begin
                res_fval_reg <= val_rd;
                res_wdel_reg <= deleted_reg[r_reg];
            end
        end

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_fval_reg   <= res_fval_reg;
            out_wdel_reg   <= res_wdel_reg;
        end
    end

    assign req.ready       = cmd.in_ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.slot_index  = SLOT_OUT_W'(out_slot_reg);
    assign rsp.found_value = out_fval_reg;
    assign rsp.was_deleted = out_wdel_reg;

    always_comb
    begin
        sts.in_valid   = req.valid;
        sts.out_free   = !out_valid_reg || rsp.ready;
        sts.hash_last  = (bcnt_reg == 2'd3);
        sts.oat_mode   = oat_mode_reg;
        sts.mod_done   = mod_done;
        sts.mod_zero   = (mod_rem == '0);
        sts.tries_max  = (32'(tries_reg) >= 32'(MAX_REHASH));
        sts.func       = func_reg;
        sts.full       = (count_reg >= m_reg);
        sts.empty      = (count_reg == '0);
        sts.scan_hit   = busy_reg[i_reg] && (key_rd == key_reg);
        sts.i_last     = (RW'(i_reg) + RW'(1) == RW'(m_reg));
        sts.probe_free = !busy_reg[r_reg];
        sts.probe_hit  = busy_reg[r_reg] && (key_rd == key_reg);
    end
endmodule

// ===== rtl/core/dhot_ctrl.sv =====
// Sequencer of the double-hash table: walks each operation through hashing,
// remainder passes, duplicate scan and probing. Depends on dhot_pkg.
module dhot_ctrl import dhot_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (sts.hash_last)
                begin
                    state_next = sts.oat_mode ? S_HFIN : S_MROT;
                end
            end
            S_HFIN:
            begin
                cmd.oat_fin = 1'b1;
                state_next  = S_MROT;
            end
            S_MROT:
            begin
                cmd.mod_start = 1'b1;
                cmd.mod_sel   = MS_ROT;
                state_next    = S_MROT_W;
            end
            S_MROT_W:
            begin
                if (sts.mod_done)
                begin
                    if (!sts.mod_zero || sts.tries_max)
                    begin
                        cmd.take_h2 = 1'b1;
                        state_next  = S_MH1;
                    end
                    else
                    begin
                        cmd.rehash_start = 1'b1;
                        state_next       = S_HASH;
                    end
                end
            end
            S_MH1:
            begin
                cmd.mod_start = 1'b1;
                cmd.mod_sel   = MS_H1;
                state_next    = S_MH1_W;
            end
            S_MH1_W:
            begin
                if (sts.mod_done)
                begin
                    cmd.take_r = 1'b1;
                    state_next = S_MC;
                end
            end
            S_MC:
            begin
                cmd.mod_start = 1'b1;
                cmd.mod_sel   = MS_ONES;
                state_next    = S_MC_W;
            end
            S_MC_W:
            begin
                if (sts.mod_done)
                begin
                    cmd.take_c  = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.func)
                    FN_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.res_code_we = 1'b1;
                            cmd.res_code    = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    FN_LOOKUP, FN_DELETE:
                    begin
                        state_next = sts.empty ? S_DONE : S_PROBE_RD;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = S_SCAN_CK;
            end
            S_SCAN_CK:
            begin
                cmd.rd_scan = 1'b1;
                if (sts.scan_hit)
                begin
                    cmd.res_code_we = 1'b1;
                    cmd.res_code    = ST_DUP;
                    state_next      = S_DONE;
                end
                else if (sts.i_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_PROBE_INS;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_PROBE_INS:
            begin
                if (sts.probe_free)
                begin
                    cmd.ins_write = 1'b1;
                    cmd.res_hit   = 1'b1;
                    state_next    = S_DONE;
                end
                else if (sts.i_last)
                begin
                    cmd.res_code_we = 1'b1;
                    cmd.res_code    = ST_NOPROBE;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.adv = 1'b1;
                end
            end
            S_PROBE_RD:
            begin
                state_next = S_PROBE_CK;
            end
            S_PROBE_CK:
            begin
                if (sts.probe_hit)
                begin
                    cmd.res_hit  = 1'b1;
                    cmd.del_mark = (sts.func == FN_DELETE);
                end
                if ((sts.probe_hit && sts.func == FN_LOOKUP) || sts.i_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.adv    = 1'b1;
                    state_next = S_PROBE_RD;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/core/double_hash_open_address_table.sv =====
// Top level of the double-hash open-addressed key table.
// Depends on dhot_pkg, dhot_req_if, dhot_rsp_if, dhot_ctrl and dhot_datapath.
//
// Stores 32-bit keys with a 32-bit record reference in up to SLOTS slots and
// serves one operation per request transaction: insert, lookup or delete
// (delete marks every matching probe and keeps the slot occupied). Slot i of
// the probe sequence is (h1 + i*h2) mod table_size in wrapping 32-bit sums,
// h1 a one-at-a-time hash and h2 a rotate-subtract hash, rehashed while its
// remainder is zero, at most MAX_REHASH times, then taken as 1. Operations
// run one at a time; a finished result waits in the output register, so the
// next request transaction is taken while the previous response is held.
// Each operation hashes the key byte by byte, then makes three passes of
// the shared bit-serial remainder unit (plus one for each rehash), then
// does the slot work: insert scans all table_size slots for duplicates and
// then probes for a free slot; lookup and delete probe through the
// registered key RAM read (delete always walks all table_size probes). The
// remainder unit and the single read port of the key RAM bound the speed.
// The user must write table_size through cfg_we/cfg_wdata only while idle;
// the block does not enforce this. Values below 2 are taken as 2 and above
// SLOTS as SLOTS. Reset empties the table at once (occupied and deleted
// marks are flip-flops).
module double_hash_open_address_table import dhot_pkg::*; #(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int MAX_REHASH = MAX_REHASH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    dhot_req_if.sink         req,
    dhot_rsp_if.source       rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);
    cmd_t cmd;
    sts_t sts;

    // Sequence each transaction through its phases.
    dhot_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Hold the table, hashes and result registers.
    dhot_datapath #(
        .SLOTS      (SLOTS),
        .MAX_REHASH (MAX_REHASH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );
endmodule

// ===== tb/tb.sv =====
// Self-checking bench for double_hash_open_address_table: a queue-fed driver,
// a response monitor and a table predictor. Depends on dhot_pkg, dhot_req_if,
// dhot_rsp_if and the block itself.
module tb;
    import dhot_pkg::*;

    localparam logic [1:0] FN_UNUSED = 2'd3;
    localparam int TBL_MAX = 64;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] value;
    } op_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  slot_index;
        logic [31:0] found_value;
        logic        was_deleted;
    } answer_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    dhot_req_if req ();
    dhot_rsp_if rsp ();

    double_hash_open_address_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Pending requests, and the answers the table should give, oldest first.
    op_t     pending_ops[$];
    answer_t answers_due[$];

    // Shadow of the table contents and its size register.
    logic        shadow_busy[TBL_MAX];
    logic [31:0] shadow_key[TBL_MAX];
    logic [31:0] shadow_val[TBL_MAX];
    logic        shadow_del[TBL_MAX];
    int unsigned shadow_count;
    int unsigned shadow_size;

    int unsigned send_gap_pct;
    int unsigned recv_gap_pct;
    logic        req_fired;
    int          errors;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 12000000);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [31:0] oat_mix(input logic [31:0] k);
        logic [31:0] h;
        h = 32'd0;
        for (int b = 0; b < 4; b++)
        begin
            h = h + ((k >> (8 * b)) & 32'hFF);
            h = h + (h << 10);
            h = h ^ (h >> 6);
        end
        h = h + (h << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        return h;
    endfunction

    function automatic logic [31:0] rot_mix(input logic [31:0] k);
        logic [31:0] h;
        h = 32'd0;
        for (int b = 0; b < 4; b++)
        begin
            h = h + ((k >> (8 * b)) & 32'hFF);
            h = h - ((h << 13) | (h >> 19));
        end
        return h;
    endfunction

    // Probe stride: rehash while the remainder is zero, give up with 1.
    function automatic logic [31:0] stride_of(input logic [31:0] k, input int unsigned m);
        logic [31:0] h;
        h = rot_mix(k);
        for (int t = 0; t <= MAX_REHASH_DEF; t++)
        begin
            if (h % m != 0) return h % m;
            if (t == MAX_REHASH_DEF) return 32'd1;
            h = rot_mix(h);
        end
        return 32'd1;
    endfunction

    // Apply one operation to the shadow table and return its answer.
    function automatic answer_t apply_op(input op_t op);
        answer_t     a;
        logic [31:0] h1;
        logic [31:0] h2;
        logic [31:0] p;
        logic        dup;
        int unsigned m;
        m = shadow_size;
        a = '{status: ST_NOTFOUND, slot_index: 6'd0, found_value: 32'd0, was_deleted: 1'b0};
        h1 = oat_mix(op.key);
        h2 = stride_of(op.key, m);
        dup = 1'b0;
        case (op.func)
            FN_INSERT:
            begin
                if (shadow_count >= m)
                    a.status = ST_FULL;
                else
                begin
                    a.status = ST_NOPROBE;
                    for (int i = 0; i < m; i++)
                        if (shadow_busy[i] && shadow_key[i] == op.key) dup = 1'b1;
                    if (dup)
                        a.status = ST_DUP;
                    else
                        for (int i = 0; i < m; i++)
                        begin
                            p = (h1 + i * h2) % m;
                            if (!shadow_busy[p])
                            begin
                                shadow_busy[p] = 1'b1;
                                shadow_key[p]  = op.key;
                                shadow_val[p]  = op.value;
                                shadow_del[p]  = 1'b0;
                                shadow_count++;
                                a.status = ST_OK;
                                a.slot_index = p[5:0];
                                break;
                            end
                        end
                end
            end
            FN_LOOKUP:
            begin
                if (shadow_count != 0)
                    for (int i = 0; i < m; i++)
                    begin
                        p = (h1 + i * h2) % m;
                        if (shadow_busy[p] && shadow_key[p] == op.key)
                        begin
                            a.status = ST_OK;
                            a.slot_index = p[5:0];
                            a.found_value = shadow_val[p];
                            a.was_deleted = shadow_del[p];
                            break;
                        end
                    end
            end
            FN_DELETE:
            begin
                if (shadow_count != 0)
                    for (int i = 0; i < m; i++)
                    begin
                        p = (h1 + i * h2) % m;
                        if (shadow_busy[p] && shadow_key[p] == op.key)
                        begin
                            if (a.status != ST_OK)
                            begin
                                a.status = ST_OK;
                                a.slot_index = p[5:0];
                            end
                            shadow_del[p] = 1'b1;
                        end
                    end
            end
            default: ;
        endcase
        return a;
    endfunction

    // Driver: advance to the next request once the current one is taken,
    // or hold valid low when the dice say so.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.func  <= FN_INSERT;
            req.key   <= '0;
            req.value <= '0;
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= ($urandom_range(99) >= recv_gap_pct);
            if (!req.valid || req_fired)
            begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    req.valid <= 1'b1;
                    req.func  <= pending_ops[0].func;
                    req.key   <= pending_ops[0].key;
                    req.value <= pending_ops[0].value;
                    void'(pending_ops.pop_front());
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Monitor: check each response transaction against the oldest answer
    // due, then predict for any request transaction taken on this edge.
    always @(posedge clk)
    begin
        answer_t got;
        answer_t want;
        op_t     taken;
        req_fired <= req.valid && req.ready;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = '{status: rsp.status, slot_index: rsp.slot_index,
                    found_value: rsp.found_value, was_deleted: rsp.was_deleted};
            if (answers_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected response: status %0d slot %0d", got.status,
                             got.slot_index);
            end
            else
            begin
                want = answers_due.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp st %0d slot %0d val %h del %b, ",
                                  "got st %0d slot %0d val %h del %b"},
                                 want.status, want.slot_index, want.found_value,
                                 want.was_deleted, got.status, got.slot_index,
                                 got.found_value, got.was_deleted);
                end
            end
        end
        if (rst_n && req.valid && req.ready)
        begin
            taken = '{func: req.func, key: req.key, value: req.value};
            answers_due.push_back(apply_op(taken));
        end
    end

    task automatic queue_op(input logic [1:0] f, input logic [31:0] k, input logic [31:0] v);
        pending_ops.push_back('{func: f, key: k, value: v});
    endtask

    // Wait until every request has been taken and every answer has arrived.
    task automatic drain();
        while (pending_ops.size() != 0 || req.valid || answers_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write the size register while the table is idle; mirror the clamp.
    task automatic set_size(input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        shadow_size = (v < 2) ? 2 : (v > TBL_MAX) ? TBL_MAX : v;
    endtask

    initial
    begin
        logic [CFG_W-1:0] sizes[12];
        logic [31:0]      key_pool[12];
        logic [31:0]      k;
        int unsigned      r;
        int unsigned      f_roll;
        sizes = '{7'd2, 7'd0, 7'd3, 7'd1, 7'd5, 7'd8, 7'd13, 7'd17, 7'd33, 7'd127, 7'd64, 7'd100};
        errors = 0;
        req_fired = 1'b0;
        send_gap_pct = 31;
        recv_gap_pct = 63;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        shadow_count = 0;
        shadow_size = CFG_RESET;
        for (int i = 0; i < TBL_MAX; i++)
        begin
            shadow_busy[i] = 1'b0;
            shadow_del[i]  = 1'b0;
            shadow_key[i]  = '0;
            shadow_val[i]  = '0;
        end
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, key and value extremes, duplicates (live and
        // deleted), delete then lookup, unused code, misses.
        queue_op(FN_LOOKUP, 32'd0, 32'd0);
        queue_op(FN_DELETE, 32'd0, 32'd0);
        queue_op(FN_INSERT, 32'd0, 32'd0);
        queue_op(FN_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_op(FN_INSERT, 32'h8000_0000, 32'hA5A5_5A5A);
        queue_op(FN_INSERT, 32'hFFFF_FFFF, 32'h0000_0001);
        queue_op(FN_INSERT, 32'd0, 32'd7);
        queue_op(FN_LOOKUP, 32'd0, 32'd0);
        queue_op(FN_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(FN_LOOKUP, 32'd5, 32'd0);
        queue_op(FN_DELETE, 32'h8000_0000, 32'd0);
        queue_op(FN_LOOKUP, 32'h8000_0000, 32'd0);
        queue_op(FN_INSERT, 32'h8000_0000, 32'd3);
        queue_op(FN_UNUSED, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_op(FN_DELETE, 32'd12345, 32'd0);
        drain();

        // Random phases over a range of sizes, extremes and clamps included.
        for (int ph = 0; ph < 12; ph++)
        begin
            set_size(sizes[ph]);
            if (ph == 4)
            begin
                send_gap_pct = 63;
                recv_gap_pct = 31;
            end
            else if (ph == 8)
            begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            // A small pool of keys per phase keeps hits and duplicates common.
            foreach (key_pool[j]) key_pool[j] = $urandom;
            for (int n = 0; n < 105; n++)
            begin
                r = $urandom_range(99);
                k = (r < 75) ? key_pool[$urandom_range(11)] : $urandom;
                f_roll = $urandom_range(99);
                if (f_roll < 40)
                    queue_op(FN_INSERT, k, $urandom);
                else if (f_roll < 70)
                    queue_op(FN_LOOKUP, k, $urandom);
                else if (f_roll < 95)
                    queue_op(FN_DELETE, k, $urandom);
                else
                    queue_op(FN_UNUSED, k, $urandom);
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
